// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the handle cache.
// Needs i_clk and i_rst_n in scope at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define MHC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mhc assertion failed");

// next-cycle implication, held off during reset
`define MHC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mhc assertion failed");

`endif

// File: src/mhc_pkg.sv
// Types, codes and default sizes for the magazine handle cache.
// No dependencies; used by mhc_ctrl, mhc_datapath and the top level.
package mhc_pkg;

    localparam int NUM_REQUESTERS = 4;
    localparam int MAG_SLOTS      = 16;
    localparam int DEPOT_MAGS     = 8;
    localparam int HANDLE_BITS    = 32;

    localparam int CAP_MIN    = 4;
    localparam int CAP_MAX    = 128;
    localparam int CFG_CAP_W  = 5;
    localparam int CFG_LIM_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_W      = 18;

    localparam logic [CFG_CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [OUT_W-1:0]     OUT_MAX   = 18'h3FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_PUT     = 2'd1,
        CMD_FAIL    = 2'd2,
        CMD_DISCARD = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_ALLOC   = 3'd1,
        ST_EXHAUST = 3'd2,
        ST_STORED  = 3'd3,
        ST_FREE    = 3'd4,
        ST_ADJ     = 3'd5
    } t_status;

    // what the decision cycle does
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_USE_L,
        ACT_USE_B,
        ACT_DEPOT_GET,
        ACT_DEPOT_PUT,
        ACT_BACKEND,
        ACT_EXHAUST,
        ACT_FREE,
        ACT_ADJ
    } t_act;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDL,
        S_RDB,
        S_DEC,
        S_SLOT,
        S_RES
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd_l;
        logic rd_b;
        logic dec;
        t_act act;
        logic slot;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic fl_zero;
        logic fb_zero;
        logic fl_lt_cap;
        logic fb_lt_cap;
        logic full_any;
        logic empty_any;
        logic under_limit;
        logic out_free;
    } t_sts;

endpackage

// File: src/mhc_req_if.sv
// Request channel of the handle cache: valid/ready plus request fields.
// Depends on nothing but the handle width parameter.
interface mhc_req_if #(parameter int HANDLE_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [1:0]             requester;
    logic [HANDLE_BITS-1:0] object_handle;

    modport source (output valid, command, requester, object_handle, input ready);
    modport sink   (input valid, command, requester, object_handle, output ready);
endinterface

// File: src/mhc_rsp_if.sv
// Response channel of the handle cache: valid/ready plus status and handle.
// Depends on nothing but the handle width parameter.
interface mhc_rsp_if #(parameter int HANDLE_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic [2:0]             status;
    logic [HANDLE_BITS-1:0] result_handle;

    modport source (output valid, status, result_handle, input ready);
    modport sink   (input valid, status, result_handle, output ready);
endinterface

// File: src/mhc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/mhc_ctrl.sv
// Sequencer of the handle cache: walks one request through its steps.
// Depends on mhc_pkg; drives the datapath by mhc_pkg::t_ctl.
module mhc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mhc_pkg::t_sts i_sts,
    output mhc_pkg::t_ctl o_ctl
);
    mhc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_ctl.act  = mhc_pkg::ACT_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            mhc_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctl.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = mhc_pkg::S_RDL;
                end
            end
            mhc_pkg::S_RDL: begin
                o_ctl.rd_l = 1'b1;
                if (i_sts.cmd == mhc_pkg::CMD_GET || i_sts.cmd == mhc_pkg::CMD_PUT) begin
                    n_state = mhc_pkg::S_RDB;
                end else begin
                    n_state = mhc_pkg::S_DEC;
                end
            end
            mhc_pkg::S_RDB: begin
                o_ctl.rd_b = 1'b1;
                n_state    = mhc_pkg::S_DEC;
            end
            mhc_pkg::S_DEC: begin
                o_ctl.dec = 1'b1;
                case (i_sts.cmd)
                    mhc_pkg::CMD_GET: begin
                        if (!i_sts.fl_zero)        o_ctl.act = mhc_pkg::ACT_USE_L;
                        else if (!i_sts.fb_zero)   o_ctl.act = mhc_pkg::ACT_USE_B;
                        else if (i_sts.full_any)   o_ctl.act = mhc_pkg::ACT_DEPOT_GET;
                        else if (i_sts.under_limit) o_ctl.act = mhc_pkg::ACT_BACKEND;
                        else                       o_ctl.act = mhc_pkg::ACT_EXHAUST;
                    end
                    mhc_pkg::CMD_PUT: begin
                        if (i_sts.fl_lt_cap)       o_ctl.act = mhc_pkg::ACT_USE_L;
                        else if (i_sts.fb_lt_cap)  o_ctl.act = mhc_pkg::ACT_USE_B;
                        else if (i_sts.empty_any)  o_ctl.act = mhc_pkg::ACT_DEPOT_PUT;
                        else                       o_ctl.act = mhc_pkg::ACT_FREE;
                    end
                    mhc_pkg::CMD_FAIL: begin
                        o_ctl.act = mhc_pkg::ACT_ADJ;
                    end
                    default: begin
                        o_ctl.act = mhc_pkg::ACT_FREE;
                    end
                endcase
                if (o_ctl.act == mhc_pkg::ACT_USE_L || o_ctl.act == mhc_pkg::ACT_USE_B ||
                    o_ctl.act == mhc_pkg::ACT_DEPOT_GET ||
                    o_ctl.act == mhc_pkg::ACT_DEPOT_PUT) begin
                    n_state = mhc_pkg::S_SLOT;
                end else begin
                    n_state = mhc_pkg::S_RES;
                end
            end
            mhc_pkg::S_SLOT: begin
                o_ctl.slot = 1'b1;
                n_state    = mhc_pkg::S_RES;
            end
            mhc_pkg::S_RES: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = mhc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhc_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// File: src/mhc_datapath.sv
// Datapath of the handle cache: magazine indexes, fill counts, depot stacks,
// slot store, backend count and the output register. Depends on mhc_pkg, mhc_ram.
module mhc_datapath #(
    parameter int NUM_REQUESTERS = mhc_pkg::NUM_REQUESTERS,
    parameter int MAG_SLOTS      = mhc_pkg::MAG_SLOTS,
    parameter int DEPOT_MAGS     = mhc_pkg::DEPOT_MAGS,
    parameter int HANDLE_BITS    = mhc_pkg::HANDLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mhc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  mhc_pkg::t_ctl                  i_ctl,
    output mhc_pkg::t_sts                  o_sts,
    input  logic [1:0]                     i_command,
    input  logic [1:0]                     i_requester,
    input  logic [HANDLE_BITS-1:0]         i_object_handle,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_status,
    output logic [HANDLE_BITS-1:0]         o_result_handle
);
    localparam int NUM_MAGS = 2 * NUM_REQUESTERS + DEPOT_MAGS;
    localparam int MW       = $clog2(NUM_MAGS);
    localparam int FW       = $clog2(MAG_SLOTS + 1);
    localparam int AW       = $clog2(NUM_MAGS * MAG_SLOTS);
    localparam int RW       = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int DW       = $clog2(DEPOT_MAGS);
    localparam int DTW      = $clog2(DEPOT_MAGS + 1);
    localparam int CAP_HI   = (MAG_SLOTS < mhc_pkg::CAP_MAX) ? MAG_SLOTS : mhc_pkg::CAP_MAX;
    localparam int OW       = mhc_pkg::OUT_W;

    // configuration
    logic [mhc_pkg::CFG_CAP_W-1:0] r_cap_cfg;
    logic [mhc_pkg::CFG_LIM_W-1:0] r_lim;

    // control state
    logic [MW-1:0]  r_loaded [NUM_REQUESTERS];
    logic [MW-1:0]  r_backup [NUM_REQUESTERS];
    logic [DTW-1:0] r_full_top, r_empty_top;
    logic [OW-1:0]  r_outst;
    logic           r_fvld [NUM_MAGS];
    logic           r_evld [DEPOT_MAGS];
    logic           r_ovalid;

    // request payload
    mhc_pkg::t_cmd    r_cmd;
    logic [RW-1:0]    r_req;
    logic [HANDLE_BITS-1:0] r_hdl;
    logic [MW-1:0]    r_l, r_b, r_t;
    logic [FW-1:0]    r_fl;
    logic [MW-1:0]    r_fill_ra;
    logic [DW-1:0]    r_e_ra;
    mhc_pkg::t_status r_status;
    logic [HANDLE_BITS-1:0] r_res;
    logic             r_pop_ok;
    logic [2:0]       r_ostatus;
    logic [HANDLE_BITS-1:0] r_ohandle;

    logic [2:0]     req_w;
    logic [RW-1:0]  req_idx;
    logic [FW-1:0]  fill_rd, fill_eff, fill_wd;
    logic [MW-1:0]  fill_ra, tmag;
    logic           fill_we;
    logic [MW-1:0]  full_rd, empty_rd, empty_eff;
    logic [DW-1:0]  full_ra, empty_ra, full_wa, empty_wa;
    logic           full_we, empty_we;
    logic [AW-1:0]  slot_base, slot_ra, slot_wa;
    logic           slot_re, slot_we;
    logic [HANDLE_BITS-1:0] slot_rd;
    logic [7:0]     cfg8, cap8;
    logic [FW-1:0]  capf;
    logic [OW-1:0]  limit;
    logic           is_get;

    // requester index wraps modulo the number of requesters
    always_comb begin
        req_w = {1'b0, i_requester};
        if (NUM_REQUESTERS < 4) begin
            for (int k = 0; k < 3; k++) begin
                if (req_w >= 3'(NUM_REQUESTERS)) req_w = req_w - 3'(NUM_REQUESTERS);
            end
        end
        req_idx = RW'(req_w);
    end

    assign cfg8  = 8'(r_cap_cfg);
    assign cap8  = (cfg8 < 8'(mhc_pkg::CAP_MIN)) ? 8'(mhc_pkg::CAP_MIN) :
                   (cfg8 > 8'(CAP_HI)) ? 8'(CAP_HI) : cfg8;
    assign capf  = FW'(cap8);
    assign limit = OW'(2 * NUM_REQUESTERS) * OW'(cap8) + OW'(r_lim);
    assign is_get = (r_cmd == mhc_pkg::CMD_GET);

    // unwritten fill counts read as zero, unwritten empty slots as their reset magazine
    assign fill_eff  = r_fvld[r_fill_ra] ? fill_rd : '0;
    assign empty_eff = r_evld[r_e_ra] ? empty_rd : MW'(2 * NUM_REQUESTERS) + MW'(r_e_ra);
    assign full_ra   = (r_full_top == '0) ? '0 : DW'(r_full_top - 1'b1);
    assign empty_ra  = (r_empty_top == '0) ? '0 : DW'(r_empty_top - 1'b1);

    always_comb begin
        case (i_ctl.act)
            mhc_pkg::ACT_USE_B:     tmag = r_b;
            mhc_pkg::ACT_DEPOT_GET: tmag = full_rd;
            mhc_pkg::ACT_DEPOT_PUT: tmag = empty_eff;
            default:                tmag = r_l;
        endcase
    end

    assign fill_ra = i_ctl.rd_l ? r_l : (i_ctl.rd_b ? r_b : tmag);

    // depot stack writes in the decision cycle
    always_comb begin
        full_we  = 1'b0;
        full_wa  = DW'(r_full_top);
        empty_we = 1'b0;
        empty_wa = DW'(r_empty_top);
        if (i_ctl.dec) begin
            if (i_ctl.act == mhc_pkg::ACT_DEPOT_GET) begin
                empty_we = (r_empty_top < DTW'(DEPOT_MAGS));
            end else if (i_ctl.act == mhc_pkg::ACT_DEPOT_PUT) begin
                if (fill_eff == '0) begin
                    // empty backup takes the place of the magazine just drawn
                    empty_we = 1'b1;
                    empty_wa = empty_ra;
                end else begin
                    full_we = (r_full_top < DTW'(DEPOT_MAGS));
                end
            end
        end
    end

    // slot access: pop reads below the fill count, push writes at it
    assign slot_base = AW'(r_t) * AW'(MAG_SLOTS);
    assign slot_ra   = slot_base + AW'(fill_eff) - 1'b1;
    assign slot_wa   = slot_base + AW'(fill_eff);
    assign slot_re   = i_ctl.slot && is_get && (fill_eff != '0);
    assign slot_we   = i_ctl.slot && !is_get && (fill_eff < FW'(MAG_SLOTS));
    assign fill_we   = slot_re || slot_we;
    assign fill_wd   = is_get ? fill_eff - 1'b1 : fill_eff + 1'b1;

    mhc_ram #(.WIDTH(FW), .DEPTH(NUM_MAGS)) u_fill (
        .i_clk(i_clk), .i_we(fill_we), .i_waddr(r_t), .i_wdata(fill_wd),
        .i_re(i_ctl.rd_l | i_ctl.rd_b | i_ctl.dec), .i_raddr(fill_ra), .o_rdata(fill_rd)
    );

    mhc_ram #(.WIDTH(MW), .DEPTH(DEPOT_MAGS)) u_full (
        .i_clk(i_clk), .i_we(full_we), .i_waddr(full_wa), .i_wdata(r_b),
        .i_re(i_ctl.rd_b), .i_raddr(full_ra), .o_rdata(full_rd)
    );

    mhc_ram #(.WIDTH(MW), .DEPTH(DEPOT_MAGS)) u_empty (
        .i_clk(i_clk), .i_we(empty_we), .i_waddr(empty_wa), .i_wdata(r_b),
        .i_re(i_ctl.rd_b), .i_raddr(empty_ra), .o_rdata(empty_rd)
    );

    mhc_ram #(.WIDTH(HANDLE_BITS), .DEPTH(NUM_MAGS * MAG_SLOTS)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_we ? slot_wa : slot_ra),
        .i_wdata(r_hdl), .i_re(slot_re), .i_raddr(slot_ra), .o_rdata(slot_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg   <= mhc_pkg::CAP_RESET;
            r_lim       <= '0;
            r_full_top  <= '0;
            r_empty_top <= DTW'(DEPOT_MAGS);
            r_outst     <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
                r_loaded[i] <= MW'(2 * i);
                r_backup[i] <= MW'(2 * i + 1);
            end
            for (int i = 0; i < NUM_MAGS; i++) r_fvld[i] <= 1'b0;
            for (int i = 0; i < DEPOT_MAGS; i++) r_evld[i] <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mhc_pkg::CFG_CAPACITY:  r_cap_cfg <= i_cfg_data[mhc_pkg::CFG_CAP_W-1:0];
                    mhc_pkg::CFG_OBJ_LIMIT: r_lim     <= i_cfg_data[mhc_pkg::CFG_LIM_W-1:0];
                    default: ;
                endcase
            end
            if (fill_we) r_fvld[r_t] <= 1'b1;
            if (empty_we) r_evld[empty_wa] <= 1'b1;
            if (i_ctl.dec) begin
                case (i_ctl.act)
                    mhc_pkg::ACT_USE_B: begin
                        r_loaded[r_req] <= r_b;
                        r_backup[r_req] <= r_l;
                    end
                    mhc_pkg::ACT_DEPOT_GET: begin
                        r_loaded[r_req] <= tmag;
                        r_backup[r_req] <= r_l;
                        r_full_top      <= r_full_top - 1'b1;
                        if (empty_we) r_empty_top <= r_empty_top + 1'b1;
                    end
                    mhc_pkg::ACT_DEPOT_PUT: begin
                        r_loaded[r_req] <= tmag;
                        r_backup[r_req] <= r_l;
                        if (fill_eff != '0) begin
                            r_empty_top <= r_empty_top - 1'b1;
                            if (full_we) r_full_top <= r_full_top + 1'b1;
                        end
                    end
                    mhc_pkg::ACT_BACKEND: begin
                        if (r_outst < mhc_pkg::OUT_MAX) r_outst <= r_outst + 1'b1;
                    end
                    mhc_pkg::ACT_FREE, mhc_pkg::ACT_ADJ: begin
                        if (r_outst != '0) r_outst <= r_outst - 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_ctl.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= mhc_pkg::t_cmd'(i_command);
            r_req <= req_idx;
            r_hdl <= i_object_handle;
            r_l   <= r_loaded[req_idx];
            r_b   <= r_backup[req_idx];
        end
        if (i_ctl.rd_l | i_ctl.rd_b | i_ctl.dec) r_fill_ra <= fill_ra;
        if (i_ctl.rd_b) begin
            r_fl   <= fill_eff;
            r_e_ra <= empty_ra;
        end
        if (i_ctl.dec) begin
            r_t   <= tmag;
            r_res <= '0;
            case (i_ctl.act)
                mhc_pkg::ACT_USE_L, mhc_pkg::ACT_USE_B,
                mhc_pkg::ACT_DEPOT_GET, mhc_pkg::ACT_DEPOT_PUT: begin
                    r_status <= is_get ? mhc_pkg::ST_HIT : mhc_pkg::ST_STORED;
                end
                mhc_pkg::ACT_BACKEND: r_status <= mhc_pkg::ST_ALLOC;
                mhc_pkg::ACT_EXHAUST: r_status <= mhc_pkg::ST_EXHAUST;
                mhc_pkg::ACT_FREE: begin
                    r_status <= mhc_pkg::ST_FREE;
                    r_res    <= r_hdl;
                end
                default: r_status <= mhc_pkg::ST_ADJ;
            endcase
        end
        if (i_ctl.slot) r_pop_ok <= (fill_eff != '0);
        if (i_ctl.load_out) begin
            r_ostatus <= r_status;
            if (r_status == mhc_pkg::ST_HIT) begin
                r_ohandle <= r_pop_ok ? slot_rd : '0;
            end else begin
                r_ohandle <= r_res;
            end
        end
    end

    assign o_sts.cmd         = r_cmd;
    assign o_sts.fl_zero     = (r_fl == '0);
    assign o_sts.fb_zero     = (fill_eff == '0);
    assign o_sts.fl_lt_cap   = (r_fl < capf);
    assign o_sts.fb_lt_cap   = (fill_eff < capf);
    assign o_sts.full_any    = (r_full_top != '0);
    assign o_sts.empty_any   = (r_empty_top != '0);
    assign o_sts.under_limit = (r_lim == '0) || (r_outst < limit);
    assign o_sts.out_free    = !r_ovalid || i_ready;

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_result_handle = r_ohandle;
endmodule

// File: src/magazine_handle_cache_core.sv
// Top level of the magazine handle cache: sequencer, datapath and checks.
// Depends on mhc_pkg, mhc_req_if, mhc_rsp_if, mhc_ctrl, mhc_datapath.
//
//   channel   dir  flow        fields
//   i_req     in   valid/ready command, requester, object_handle
//   o_rsp     out  valid/ready status, result_handle
//   i_cfg_*   in   write only  i_cfg_idx, i_cfg_data
//
// One request at a time. A request served from a magazine steps through reading
// the loaded fill count, reading the backup fill count and depot stack tops, the
// decision, the slot store access and the result; a get or put that ends at the
// backend, exhausted or freed skips the slot access; a failure or discard skips both.
// Reset is synchronous; no clearing pass. A result not yet taken holds the
// next request in its last step; input is taken again once that one is out.
`include "assert_macros.svh"
module magazine_handle_cache_core #(
    parameter int NUM_REQUESTERS = mhc_pkg::NUM_REQUESTERS,
    parameter int MAG_SLOTS      = mhc_pkg::MAG_SLOTS,
    parameter int DEPOT_MAGS     = mhc_pkg::DEPOT_MAGS,
    parameter int HANDLE_BITS    = mhc_pkg::HANDLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mhc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mhc_req_if.sink                        i_req,
    mhc_rsp_if.source                      o_rsp
);
    mhc_pkg::t_ctl ctl;
    mhc_pkg::t_sts sts;
    logic          rsp_no_handle;

    mhc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .i_sts(sts), .o_ctl(ctl)
    );

    mhc_datapath #(
        .NUM_REQUESTERS(NUM_REQUESTERS), .MAG_SLOTS(MAG_SLOTS),
        .DEPOT_MAGS(DEPOT_MAGS), .HANDLE_BITS(HANDLE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_ctl(ctl), .o_sts(sts),
        .i_command(i_req.command), .i_requester(i_req.requester),
        .i_object_handle(i_req.object_handle),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready),
        .o_status(o_rsp.status), .o_result_handle(o_rsp.result_handle)
    );

    assign rsp_no_handle = (o_rsp.status == mhc_pkg::ST_ALLOC) ||
                           (o_rsp.status == mhc_pkg::ST_EXHAUST) ||
                           (o_rsp.status == mhc_pkg::ST_STORED) ||
                           (o_rsp.status == mhc_pkg::ST_ADJ);

    // an accepted request keeps the block busy for the next cycle
    `MHC_ASSERT_NXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    // a new result only ever follows work in progress
    `MHC_ASSERT_IMP(a_rsp_after_work, $rose(o_rsp.valid), $past(!i_req.ready))
    // statuses without a handle carry zero
    `MHC_ASSERT_IMP(a_zero_handle, o_rsp.valid && rsp_no_handle, o_rsp.result_handle == '0)
endmodule
